/* hdl/pkl_pkg.sv */
// Pressed key list: shared codes and controller/datapath interface structs.
// No dependencies.
package pkl_pkg;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;
  localparam logic [2:0] ST_ZERO    = 3'd6;
  localparam logic [2:0] ST_BADOP   = 3'd7;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       append;
    logic       remove;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       rpt_load;
    logic [2:0] status;
  } pkl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       code_zero;
    logic       hit;
    logic       at_end;
    logic       full;
    logic       rpt_last;
    logic       out_free;
  } pkl_flags_t;

endpackage

/* hdl/pkl_datapath.sv */
// Pressed key list datapath: slot cells, count, scan pointer, output word register.
// Depends on pkl_pkg.
module pkl_datapath
  import pkl_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pkl_cmd_t   cmd,
  output pkl_flags_t flags,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_slot_index,
  output logic [7:0] out_slot_key,
  output logic [3:0] out_key_count,
  output logic [2:0] out_status,
  output logic       out_last
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NREP = (CAPACITY < 8) ? CAPACITY : 8;

  logic [7:0]    slots_r [CAPACITY];
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;
  logic [1:0]    op_r;
  logic [7:0]    code_r;
  logic [7:0]    rd_key;

  logic          out_valid_r;
  logic [2:0]    out_slot_index_r;
  logic [7:0]    out_slot_key_r;
  logic [3:0]    out_key_count_r;
  logic [2:0]    out_status_r;
  logic          out_last_r;

  always_comb begin
    rd_key = '0;
    if (ptr_r < CW'(CAPACITY)) begin
      rd_key = slots_r[ptr_r[IW-1:0]];
    end
  end

  assign flags.op        = op_r;
  assign flags.code_zero = (code_r == 8'd0);
  assign flags.hit       = (rd_key == code_r);
  assign flags.at_end    = (ptr_r == count_r);
  assign flags.full      = (count_r == CW'(CAPACITY));
  assign flags.rpt_last  = (ptr_r == CW'(NREP - 1));
  assign flags.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      code_r <= in_key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.remove) begin
      count_r <= count_r - CW'(1);
    end
  end

  // each cell takes its upper neighbor when a code at or below it leaves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i < CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (!rst_n || cmd.clear) begin
          slots_r[i] <= '0;
        end else if (cmd.append && count_r == CW'(i)) begin
          slots_r[i] <= code_r;
        end else if (cmd.remove) begin
          if (CW'(i) == count_r - CW'(1)) begin
            slots_r[i] <= '0;
          end else if (CW'(i) >= ptr_r && CW'(i) < count_r) begin
            slots_r[i] <= slots_r[i+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (!rst_n || cmd.clear) begin
          slots_r[i] <= '0;
        end else if (cmd.append && count_r == CW'(i)) begin
          slots_r[i] <= code_r;
        end else if (cmd.remove && CW'(i) == count_r - CW'(1)) begin
          slots_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rpt_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rpt_load) begin
      out_slot_index_r <= 3'(ptr_r);
      out_slot_key_r   <= rd_key;
      out_key_count_r  <= 4'(count_r);
      out_status_r     <= cmd.status;
      out_last_r       <= flags.rpt_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_index_r;
  assign out_slot_key   = out_slot_key_r;
  assign out_key_count  = out_key_count_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append && !cmd.clear |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove && !cmd.clear |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not shrink the list");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rpt_load && flags.rpt_last |=> out_valid_r && out_last_r)
    else $error("final slot word not marked last");
`endif

endmodule

/* hdl/pkl_ctrl.sv */
// Pressed key list controller: sequences decode, scan, update and slot report.
// Depends on pkl_pkg.
module pkl_ctrl
  import pkl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pkl_flags_t flags,
  output pkl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_REPORT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    cmd          = '0;
    cmd.status   = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.ptr_clr = 1'b1;
        state_nxt   = S_REPORT;
        if (flags.op == OP_CLEAR) begin
          cmd.clear  = 1'b1;
          status_nxt = ST_CLEARED;
        end else if (flags.op != OP_PRESS && flags.op != OP_RELEASE) begin
          status_nxt = ST_BADOP;
        end else if (flags.code_zero) begin
          status_nxt = ST_ZERO;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (flags.at_end) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_REPORT;
          if (flags.op == OP_PRESS) begin
            if (flags.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.append = 1'b1;
              status_nxt = ST_ADDED;
            end
          end else begin
            status_nxt = ST_ABSENT;
          end
        end else if (flags.hit) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_REPORT;
          if (flags.op == OP_PRESS) begin
            status_nxt = ST_PRESENT;
          end else begin
            cmd.remove = 1'b1;
            status_nxt = ST_REMOVED;
          end
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_REPORT: begin
        if (flags.out_free) begin
          cmd.rpt_load = 1'b1;
          cmd.ptr_inc  = 1'b1;
          if (flags.rpt_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_ADDED;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE && !in_stall)
    else $error("word taken outside idle");

  a_update_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.append, cmd.remove}))
    else $error("conflicting list updates");

  a_decode_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECODE)
    else $error("accepted word not decoded");
`endif

endmodule

/* hdl/pressed_key_list_unit.sv */
// Pressed key list top level: ordered list of held key codes with per-slot report.
// Depends on pkl_pkg, pkl_ctrl, pkl_datapath.
//
//  channel  ports                                   direction
//  in       in_valid/in_stall, in_operation,        event word in
//           in_key_code
//  out      out_valid/out_stall, out_slot_index,    one word per reported slot
//           out_slot_key, out_key_count, out_status, out_last
//
// An event passes through accept, decode, a scan of the stored slots
// (one slot compare per cycle) and a report of min(CAPACITY,8) words, one per slot.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// in_stall is high from accept until the final word is loaded into the output
// register; out_stall holds the output register and pauses the report.
module pressed_key_list_unit
  import pkl_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_slot_index,
  output logic [7:0] out_slot_key,
  output logic [3:0] out_key_count,
  output logic [2:0] out_status,
  output logic       out_last
);

  pkl_cmd_t   cmd;
  pkl_flags_t flags;

  pkl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  pkl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .flags          (flags),
    .in_operation   (in_operation),
    .in_key_code    (in_key_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_slot_key   (out_slot_key),
    .out_key_count  (out_key_count),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule
